/* rtl/mcps_pkg.sv */
`timescale 1ns / 1ps
package mcps_pkg;

   localparam int SCAN_STEPS   = 20;
   localparam int NUM_CHANNELS = 6;
   localparam int STEP_W       = 5;
   localparam int CHAN_W       = 3;
   localparam int CNT_W        = 16;
   localparam int RETRY_W      = 4;
   localparam int VALUE_W      = 24;
   localparam int TABLE_W      = 48;
   localparam int ADDR_W       = 6;
   localparam int DATA_W       = 64;
   localparam int FIFO_DEPTH   = 4;
   localparam int FIFO_PTR_W   = 2;
   localparam int FIFO_CNT_W   = 3;

   typedef enum logic [1:0] {
      KIND_ISSUE   = 2'd0,
      KIND_MEASURE = 2'd1,
      KIND_ABANDON = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      REG_AUTO_ENABLE   = 3'd0,
      REG_SCAN_PERIOD   = 3'd1,
      REG_REPLY_TIMEOUT = 3'd2,
      REG_RETRY_LIMIT   = 3'd3,
      REG_READ_COMMAND  = 3'd4,
      REG_CHANNEL_TABLE = 3'd5
   } reg_index_type;

   localparam logic ACTION_TICK = 1'b0;

   typedef struct packed {
      logic                 auto_enable;
      logic [CNT_W-1:0]     scan_period;
      logic [CNT_W-1:0]     reply_timeout;
      logic [RETRY_W-1:0]   retry_limit;
      logic [7:0]           read_command;
      logic [TABLE_W-1:0]   channel_reg_table;
   } cfg_type;

   typedef struct packed {
      logic       action;
      logic [7:0] resp_byte0;
      logic [7:0] resp_byte1;
      logic [7:0] resp_byte2;
      logic [7:0] resp_check;
   } req_word_type;

   typedef struct packed {
      kind_type           kind;
      logic [7:0]         cmd_byte;
      logic [7:0]         reg_addr;
      logic [CHAN_W-1:0]  channel;
      logic [VALUE_W-1:0] value;
      logic               last;
   } rsp_word_type;

   typedef struct packed {
      logic [1:0]   count;
      rsp_word_type word0;
      rsp_word_type word1;
   } push_type;

   function automatic logic [7:0] reg_of(input logic [TABLE_W-1:0] tbl,
                                         input logic [CHAN_W-1:0] ch);
      logic [CHAN_W-1:0] k;
      k = ch - CHAN_W'(1);
      if (k > CHAN_W'(5)) begin
         return 8'd0;
      end
      return tbl[k*8 +: 8];
   endfunction

   function automatic logic [CHAN_W-1:0] dest_of(input logic [CHAN_W-1:0] ch);
      return (ch == CHAN_W'(1)) ? CHAN_W'(0) : ch;
   endfunction

endpackage

/* rtl/mcps_req_if.sv */
`timescale 1ns / 1ps
interface mcps_req_if;
   import mcps_pkg::*;
   logic         valid;
   logic         ready;
   req_word_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* rtl/mcps_rsp_if.sv */
`timescale 1ns / 1ps
interface mcps_rsp_if;
   import mcps_pkg::*;
   logic         valid;
   logic         ready;
   rsp_word_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* rtl/mcps_csr.sv */
`timescale 1ns / 1ps
module mcps_csr
   import mcps_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg
);

   cfg_type       cfg_ff, cfg_in;
   reg_index_type idx;
   logic          wr_en;

   assign idx    = reg_index_type'(paddr[ADDR_W-1:3]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_AUTO_ENABLE:   cfg_in.auto_enable       = pwdata[0];
            REG_SCAN_PERIOD:   cfg_in.scan_period       = pwdata[CNT_W-1:0];
            REG_REPLY_TIMEOUT: cfg_in.reply_timeout     = pwdata[CNT_W-1:0];
            REG_RETRY_LIMIT:   cfg_in.retry_limit       = pwdata[RETRY_W-1:0];
            REG_READ_COMMAND:  cfg_in.read_command      = pwdata[7:0];
            REG_CHANNEL_TABLE: cfg_in.channel_reg_table = pwdata[TABLE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (idx)
         REG_AUTO_ENABLE:   prdata = DATA_W'(cfg_ff.auto_enable);
         REG_SCAN_PERIOD:   prdata = DATA_W'(cfg_ff.scan_period);
         REG_REPLY_TIMEOUT: prdata = DATA_W'(cfg_ff.reply_timeout);
         REG_RETRY_LIMIT:   prdata = DATA_W'(cfg_ff.retry_limit);
         REG_READ_COMMAND:  prdata = DATA_W'(cfg_ff.read_command);
         REG_CHANNEL_TABLE: prdata = DATA_W'(cfg_ff.channel_reg_table);
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.auto_enable       <= 1'b1;
         cfg_ff.scan_period       <= CNT_W'(4000);
         cfg_ff.reply_timeout     <= CNT_W'(100);
         cfg_ff.retry_limit       <= RETRY_W'(5);
         cfg_ff.read_command      <= 8'd0;
         cfg_ff.channel_reg_table <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* rtl/mcps_engine.sv */
`timescale 1ns / 1ps
module mcps_engine
   import mcps_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   mcps_req_if.sink req,
   input  logic    space,
   output push_type push
);

   logic                in_valid_ff, in_valid_in;
   req_word_type        in_word_ff;
   logic                fire;

   logic [CNT_W-1:0]    period_count_ff, period_count_in;
   logic [CNT_W-1:0]    timeout_count_ff, timeout_count_in;
   logic                waiting_ff, waiting_in;
   logic                busy_ff, busy_in;
   logic [STEP_W-1:0]   scan_step_ff, scan_step_in;
   logic [CHAN_W-1:0]   pending_ff, pending_in;
   logic [RETRY_W-1:0]  retry_ff, retry_in;

   assign fire        = in_valid_ff && space;
   assign req.ready   = !in_valid_ff || fire;
   assign in_valid_in = (req.valid && req.ready) || (in_valid_ff && !fire);

   always_comb begin
      logic         timed_out;
      logic         need_retry;
      logic         ev_valid;
      kind_type     ev_kind;
      logic [VALUE_W-1:0] ev_value;
      logic         sc_valid;
      logic [7:0]   ev_reg;
      logic [7:0]   sum;
      rsp_word_type ev_word, sc_word;

      period_count_in  = period_count_ff;
      timeout_count_in = timeout_count_ff;
      waiting_in       = waiting_ff;
      busy_in          = busy_ff;
      scan_step_in     = scan_step_ff;
      pending_in       = pending_ff;
      retry_in         = retry_ff;
      timed_out        = 1'b0;
      need_retry       = 1'b0;
      ev_valid         = 1'b0;
      ev_kind          = KIND_ISSUE;
      ev_value         = '0;
      sc_valid         = 1'b0;
      ev_reg           = reg_of(cfg.channel_reg_table, pending_ff);
      sum              = cfg.read_command + ev_reg + in_word_ff.resp_byte0
                         + in_word_ff.resp_byte1 + in_word_ff.resp_byte2;

      if (in_word_ff.action == ACTION_TICK) begin
         if (waiting_ff) begin
            timeout_count_in = timeout_count_ff + CNT_W'(1);
            if (timeout_count_in >= cfg.reply_timeout) begin
               timeout_count_in = '0;
               waiting_in       = 1'b0;
               timed_out        = 1'b1;
            end
         end else begin
            timeout_count_in = '0;
         end
         if (cfg.auto_enable) begin
            period_count_in = period_count_ff + CNT_W'(1);
            if (period_count_in >= cfg.scan_period) begin
               period_count_in  = '0;
               scan_step_in     = STEP_W'(SCAN_STEPS);
               busy_in          = 1'b0;
               waiting_in       = 1'b0;
               timed_out        = 1'b0;
               timeout_count_in = '0;
            end
         end else begin
            period_count_in = '0;
         end
         need_retry = timed_out && busy_in;
      end else if (busy_ff) begin
         if (in_word_ff.resp_check == ~sum) begin
            busy_in          = 1'b0;
            waiting_in       = 1'b0;
            timeout_count_in = '0;
            retry_in         = '0;
            ev_valid         = 1'b1;
            ev_kind          = KIND_MEASURE;
            ev_value         = {in_word_ff.resp_byte0, in_word_ff.resp_byte1,
                                in_word_ff.resp_byte2};
         end else begin
            need_retry = 1'b1;
         end
      end

      if (need_retry) begin
         ev_valid         = 1'b1;
         timeout_count_in = '0;
         if (retry_ff < cfg.retry_limit) begin
            retry_in   = retry_ff + RETRY_W'(1);
            busy_in    = 1'b1;
            waiting_in = 1'b1;
            ev_kind    = KIND_ISSUE;
         end else begin
            busy_in    = 1'b0;
            waiting_in = 1'b0;
            retry_in   = '0;
            ev_kind    = KIND_ABANDON;
         end
      end

      if (!busy_in && scan_step_in != '0) begin
         if (scan_step_in <= STEP_W'(NUM_CHANNELS)) begin
            pending_in       = scan_step_in[CHAN_W-1:0];
            retry_in         = '0;
            busy_in          = 1'b1;
            waiting_in       = 1'b1;
            timeout_count_in = '0;
            sc_valid         = 1'b1;
         end
         scan_step_in = scan_step_in - STEP_W'(1);
      end

      ev_word.kind     = ev_kind;
      ev_word.cmd_byte = cfg.read_command;
      ev_word.reg_addr = ev_reg;
      ev_word.channel  = dest_of(pending_ff);
      ev_word.value    = ev_value;
      ev_word.last     = !sc_valid;

      sc_word.kind     = KIND_ISSUE;
      sc_word.cmd_byte = cfg.read_command;
      sc_word.reg_addr = reg_of(cfg.channel_reg_table, pending_in);
      sc_word.channel  = dest_of(pending_in);
      sc_word.value    = '0;
      sc_word.last     = 1'b1;

      push.word0 = ev_valid ? ev_word : sc_word;
      push.word1 = sc_word;
      push.count = fire ? (2'(ev_valid) + 2'(sc_valid)) : 2'd0;
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_word_ff <= req.payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         period_count_ff  <= '0;
         timeout_count_ff <= '0;
         waiting_ff       <= 1'b0;
         busy_ff          <= 1'b0;
         scan_step_ff     <= '0;
         pending_ff       <= '0;
         retry_ff         <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (fire) begin
            period_count_ff  <= period_count_in;
            timeout_count_ff <= timeout_count_in;
            waiting_ff       <= waiting_in;
            busy_ff          <= busy_in;
            scan_step_ff     <= scan_step_in;
            pending_ff       <= pending_in;
            retry_ff         <= retry_in;
         end
      end
   end

endmodule

/* rtl/mcps_rsp_fifo.sv */
`timescale 1ns / 1ps
module mcps_rsp_fifo
   import mcps_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   output logic     space,
   mcps_rsp_if.source rsp
);

   rsp_word_type          mem [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;
   logic                  pop;

   assign space       = count_ff <= FIFO_CNT_W'(FIFO_DEPTH - 2);
   assign rsp.valid   = count_ff != '0;
   assign rsp.payload = mem[rd_ptr_ff];
   assign pop         = rsp.valid && rsp.ready;

   assign wr_ptr_in = wr_ptr_ff + FIFO_PTR_W'(push.count);
   assign rd_ptr_in = rd_ptr_ff + FIFO_PTR_W'(pop);
   assign count_in  = count_ff + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem[wr_ptr_ff] <= push.word0;
      end
      if (push.count == 2'd2) begin
         mem[wr_ptr_ff + FIFO_PTR_W'(1)] <= push.word1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* rtl/meter_channel_poll_sequencer.sv */
`timescale 1ns / 1ps
// Poll sequencer for a six-channel metering chip. Each req word is a timer tick or a
// four-byte read response; each rsp word is a read to issue, a measurement or an abandoned
// read, and an item yields zero, one or two words, the final one flagged by last. A new
// item is taken every cycle unless stalled: it lands in an input register and is evaluated
// in one pass, its words going into a four-entry result queue, which registers them before
// the first word is offered. req.ready drops only while that queue cannot take two more
// words, so the sustained rate is one item per cycle, bounded by the rsp side at one word
// per cycle. Registers sit on the APB port at byte address 8*i.
module meter_channel_poll_sequencer
   import mcps_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   mcps_req_if.sink          req,
   mcps_rsp_if.source        rsp,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   cfg_type  cfg;
   push_type push;
   logic     space;

   mcps_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   mcps_engine u_engine (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .req   (req),
      .space (space),
      .push  (push)
   );

   mcps_rsp_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .space (space),
      .rsp   (rsp)
   );

endmodule

/* bench/poll_sequence_checker.sv */
`timescale 1ns / 1ps
module poll_sequence_checker
   import mcps_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   mcps_req_if               req,
   mcps_rsp_if               rsp,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic              pready,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output int unsigned       mismatches,
   output int unsigned       words_due
);

   cfg_type            setting;
   logic [CNT_W-1:0]   period_count;
   logic [CNT_W-1:0]   timeout_count;
   logic               waiting;
   logic               busy;
   logic [STEP_W-1:0]  scan_step;
   logic [CHAN_W-1:0]  pending_channel;
   logic [RETRY_W-1:0] retry_count;

   rsp_word_type awaited_words[$];
   rsp_word_type item_words[$];

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatches++;
      if (mismatches <= 100) begin
         $display("mismatch at %0t ns: %s got 0x%0h want 0x%0h", $time, what, got, want);
      end
   endtask

   function automatic logic [7:0] table_byte(input logic [CHAN_W-1:0] ch);
      logic [CHAN_W-1:0] k;
      k = ch - CHAN_W'(1);
      if (k > CHAN_W'(5)) begin
         return 8'd0;
      end
      return setting.channel_reg_table[k*8 +: 8];
   endfunction

   function automatic rsp_word_type outcome(input kind_type k, input logic [VALUE_W-1:0] v);
      rsp_word_type w;
      w.kind     = k;
      w.cmd_byte = setting.read_command;
      w.reg_addr = table_byte(pending_channel);
      w.channel  = (pending_channel == CHAN_W'(1)) ? '0 : pending_channel;
      w.value    = v;
      w.last     = 1'b0;
      return w;
   endfunction

   task automatic retry_or_give_up();
      if (retry_count < setting.retry_limit) begin
         retry_count   = retry_count + RETRY_W'(1);
         busy          = 1'b1;
         waiting       = 1'b1;
         timeout_count = '0;
         item_words.push_back(outcome(KIND_ISSUE, '0));
      end else begin
         busy          = 1'b0;
         waiting       = 1'b0;
         timeout_count = '0;
         retry_count   = '0;
         item_words.push_back(outcome(KIND_ABANDON, '0));
      end
   endtask

   // one accepted word: tick (timeout, then scan period) or response, then the scan step
   task automatic advance_poller(input req_word_type w);
      logic       timed_out;
      logic [7:0] sum8;
      timed_out = 1'b0;
      item_words.delete();
      if (w.action == ACTION_TICK) begin
         if (waiting) begin
            timeout_count = timeout_count + CNT_W'(1);
            if (timeout_count >= setting.reply_timeout) begin
               timeout_count = '0;
               waiting       = 1'b0;
               timed_out     = 1'b1;
            end
         end else begin
            timeout_count = '0;
         end
         if (setting.auto_enable) begin
            period_count = period_count + CNT_W'(1);
            if (period_count >= setting.scan_period) begin
               period_count  = '0;
               scan_step     = STEP_W'(SCAN_STEPS);
               busy          = 1'b0;
               waiting       = 1'b0;
               timed_out     = 1'b0;
               timeout_count = '0;
            end
         end else begin
            period_count = '0;
         end
         if (timed_out && busy) begin
            retry_or_give_up();
         end
      end else if (busy) begin
         sum8 = setting.read_command + table_byte(pending_channel) + w.resp_byte0
                + w.resp_byte1 + w.resp_byte2;
         if (w.resp_check == 8'hff - sum8) begin
            busy          = 1'b0;
            waiting       = 1'b0;
            timeout_count = '0;
            retry_count   = '0;
            item_words.push_back(outcome(KIND_MEASURE,
                                         {w.resp_byte0, w.resp_byte1, w.resp_byte2}));
         end else begin
            retry_or_give_up();
         end
      end
      if (!busy && scan_step != '0) begin
         if (scan_step <= NUM_CHANNELS) begin
            pending_channel = scan_step[CHAN_W-1:0];
            retry_count     = '0;
            busy            = 1'b1;
            waiting         = 1'b1;
            timeout_count   = '0;
            item_words.push_back(outcome(KIND_ISSUE, '0));
         end
         scan_step = scan_step - STEP_W'(1);
      end
      if (item_words.size() > 0) begin
         item_words[item_words.size()-1].last = 1'b1;
      end
      foreach (item_words[i]) begin
         awaited_words.push_back(item_words[i]);
      end
   endtask

   always @(posedge clock) begin
      rsp_word_type got;
      rsp_word_type want;
      if (reset) begin
         setting.auto_enable       = 1'b1;
         setting.scan_period       = CNT_W'(4000);
         setting.reply_timeout     = CNT_W'(100);
         setting.retry_limit       = RETRY_W'(5);
         setting.read_command      = 8'd0;
         setting.channel_reg_table = '0;
         period_count    = '0;
         timeout_count   = '0;
         waiting         = 1'b0;
         busy            = 1'b0;
         scan_step       = '0;
         pending_channel = '0;
         retry_count     = '0;
         awaited_words.delete();
         words_due <= 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (reg_index_type'(paddr[5:3]))
               REG_AUTO_ENABLE:   setting.auto_enable       = pwdata[0];
               REG_SCAN_PERIOD:   setting.scan_period       = pwdata[CNT_W-1:0];
               REG_REPLY_TIMEOUT: setting.reply_timeout     = pwdata[CNT_W-1:0];
               REG_RETRY_LIMIT:   setting.retry_limit       = pwdata[RETRY_W-1:0];
               REG_READ_COMMAND:  setting.read_command      = pwdata[7:0];
               REG_CHANNEL_TABLE: setting.channel_reg_table = pwdata[TABLE_W-1:0];
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            got = rsp.payload;
            if (awaited_words.size() == 0) begin
               report_mismatch("rsp word with none awaited", 64'(got), '0);
            end else begin
               want = awaited_words.pop_front();
               if (got.kind !== want.kind) report_mismatch("kind", got.kind, want.kind);
               if (got.cmd_byte !== want.cmd_byte) begin
                  report_mismatch("cmd_byte", got.cmd_byte, want.cmd_byte);
               end
               if (got.reg_addr !== want.reg_addr) begin
                  report_mismatch("reg_addr", got.reg_addr, want.reg_addr);
               end
               if (got.channel !== want.channel) begin
                  report_mismatch("channel", got.channel, want.channel);
               end
               if (got.value !== want.value) report_mismatch("value", got.value, want.value);
               if (got.last !== want.last) report_mismatch("last", got.last, want.last);
            end
         end
         if (req.valid && req.ready) begin
            advance_poller(req.payload);
         end
         words_due <= awaited_words.size();
      end
   end

endmodule

/* bench/meter_channel_poll_sequencer_test.sv */
`timescale 1ns / 1ps
module meter_channel_poll_sequencer_test;
   import mcps_pkg::*;

   localparam logic        ACTION_RESPONSE = ~ACTION_TICK;
   localparam int unsigned CYCLE_LIMIT     = 300000;

   typedef enum logic [1:0] {RX_OPEN, RX_CHOPPY, RX_CHOKED} rx_pace_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   int unsigned mismatches;
   int unsigned words_due;
   int unsigned cycle_count = 0;
   int unsigned issue_seen = 0;
   int unsigned issue_answered = 0;
   logic [7:0]  owed_reg = 8'd0;
   logic [7:0]  cur_cmd;
   logic [47:0] cur_table;
   rx_pace_type rx_pace = RX_OPEN;
   int unsigned rx_left = 0;

   mcps_req_if req_ch ();
   mcps_rsp_if rsp_ch ();

   meter_channel_poll_sequencer dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   poll_sequence_checker poll_check (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .rsp        (rsp_ch),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .pready     (pready),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .mismatches (mismatches),
      .words_due  (words_due)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("meter_channel_poll_sequencer verification failed");
         $finish;
      end
   end

   // receiver pace changes in stretches
   always @(posedge clock) begin
      if (rx_left == 0) begin
         rx_pace <= rx_pace_type'($urandom_range(0, 2));
         rx_left <= $urandom_range(4, 40);
      end else begin
         rx_left <= rx_left - 1;
      end
      case (rx_pace)
         RX_OPEN:   rsp_ch.ready <= 1'b1;
         RX_CHOPPY: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
         default:   rsp_ch.ready <= ($urandom_range(0, 5) == 0);
      endcase
   end

   // last read the block asked for, so responses can carry a matching checksum
   always @(posedge clock) begin
      if (rsp_ch.valid && rsp_ch.ready && rsp_ch.payload.kind == KIND_ISSUE) begin
         owed_reg   <= rsp_ch.payload.reg_addr;
         issue_seen <= issue_seen + 1;
      end
   end

   function automatic logic [7:0] chan_reg(input int ch);
      return cur_table[(ch-1)*8 +: 8];
   endfunction

   function automatic req_word_type flat_word(input logic act, input logic [7:0] fill);
      req_word_type w;
      w.action     = act;
      w.resp_byte0 = fill;
      w.resp_byte1 = fill;
      w.resp_byte2 = fill;
      w.resp_check = fill;
      return w;
   endfunction

   function automatic req_word_type loose_word(input logic act);
      req_word_type w;
      w.action     = act;
      w.resp_byte0 = 8'($urandom);
      w.resp_byte1 = 8'($urandom);
      w.resp_byte2 = 8'($urandom);
      w.resp_check = 8'($urandom);
      return w;
   endfunction

   function automatic req_word_type resp_word(input logic [7:0] addr,
                                              input logic [23:0] v, input bit corrupt);
      req_word_type w;
      logic [7:0]   sum8;
      sum8 = cur_cmd + addr + v[23:16] + v[15:8] + v[7:0];
      w.action = ACTION_RESPONSE;
      {w.resp_byte0, w.resp_byte1, w.resp_byte2} = v;
      w.resp_check = 8'hff - sum8;
      if (corrupt) begin
         w.resp_check = w.resp_check ^ 8'($urandom_range(1, 255));
      end
      return w;
   endfunction

   function automatic req_word_type next_word();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (issue_seen != issue_answered && pick < 60) begin
         issue_answered = issue_seen;
         return resp_word(owed_reg, 24'($urandom), $urandom_range(0, 9) == 0);
      end
      if (pick >= 88) begin
         return loose_word(ACTION_RESPONSE);
      end
      return loose_word(ACTION_TICK);
   endfunction

   task automatic push_word(input req_word_type w);
      req_ch.valid   <= 1'b1;
      req_ch.payload <= w;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic write_csr(input reg_index_type idx, input logic [DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
   endtask

   task automatic load_setting(input logic auto_on, input logic [15:0] period,
                               input logic [15:0] timeout, input logic [3:0] limit,
                               input logic [7:0] cmd, input logic [47:0] tbl);
      cur_cmd   = cmd;
      cur_table = tbl;
      write_csr(REG_AUTO_ENABLE, DATA_W'(auto_on));
      write_csr(REG_SCAN_PERIOD, DATA_W'(period));
      write_csr(REG_REPLY_TIMEOUT, DATA_W'(timeout));
      write_csr(REG_RETRY_LIMIT, DATA_W'(limit));
      write_csr(REG_READ_COMMAND, DATA_W'(cmd));
      write_csr(REG_CHANNEL_TABLE, DATA_W'(tbl));
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (words_due != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic run_phase(input int p);
      int unsigned quota;
      int unsigned sent;
      int unsigned burst;
      int unsigned gap;
      bit          steady;
      settle();
      steady = 1'b0;
      case (p)
         0: begin
            load_setting(1'b1, 16'd48, 16'd8, 4'd5, 8'($urandom), 48'({$urandom, $urandom}));
            quota = 150;
         end
         1: begin
            load_setting(1'b1, 16'd120, 16'd1, 4'd15, 8'($urandom),
                         48'({$urandom, $urandom}));
            quota = 150;
         end
         2: begin
            load_setting(1'b1, 16'd30, 16'd3, 4'd0, 8'h00, 48'h0);
            quota = 130;
         end
         3: begin
            load_setting(1'b1, 16'hffff, 16'hffff, 4'd15, 8'hff, 48'hffff_ffff_ffff);
            quota = 60;
         end
         4: begin
            load_setting(1'b1, 16'd22, 16'd5, 4'd2, 8'($urandom), 48'({$urandom, $urandom}));
            quota  = 150;
            steady = 1'b1;
         end
         5: begin
            load_setting(1'b0, 16'd40, 16'd4, 4'd3, 8'($urandom), 48'({$urandom, $urandom}));
            quota = 40;
         end
         6: begin
            load_setting(1'b1, 16'd64, 16'd20, 4'd1, 8'($urandom),
                         48'({$urandom, $urandom}));
            quota = 150;
         end
         default: begin
            load_setting(1'b1, 16'd35, 16'd2, 4'd4, 8'($urandom), 48'({$urandom, $urandom}));
            quota = 120;
         end
      endcase
      issue_answered = issue_seen;
      sent = 0;
      while (sent < quota) begin
         burst = $urandom_range(1, 24);
         for (int i = 0; i < burst && sent < quota; i++) begin
            push_word(next_word());
            sent++;
         end
         gap = (steady || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   initial begin
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready   = 1'b0;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // scan every tick; ignored responses walk the countdown down to the reads
      load_setting(1'b1, 16'd1, 16'd1, 4'd1, 8'ha5, 48'h1f2e_3d4c_5b6a);
      push_word(flat_word(ACTION_TICK, 8'hff));
      for (int k = 0; k < 14; k++) begin
         push_word(flat_word(ACTION_RESPONSE, (k % 2 == 1) ? 8'hff : 8'h00));
      end
      push_word(resp_word(chan_reg(6), 24'h000000, 1'b0));
      push_word(resp_word(chan_reg(5), 24'h5a5a5a, 1'b1));
      push_word(resp_word(chan_reg(5), 24'ha5a5a5, 1'b1));
      push_word(resp_word(chan_reg(4), 24'hffffff, 1'b0));
      push_word(flat_word(ACTION_TICK, 8'h00));
      push_word(resp_word(chan_reg(3), 24'h123456, 1'b0));

      for (int p = 0; p < 8; p++) begin
         run_phase(p);
      end
      settle();

      if (mismatches == 0) begin
         $display("meter_channel_poll_sequencer verification clean");
      end else begin
         $display("meter_channel_poll_sequencer verification failed");
      end
      $finish;
   end

endmodule
